@@ sv/eld_pkg.sv @@
// ----------------------------------------------------------------------------
// eld_pkg: shared types and constants of the encoder link frame decoder
// Request flag codes, status codes, state and result records, and the CRC-4
// column table used to check resync frames.
// ----------------------------------------------------------------------------
`default_nettype none

package eld_pkg;

  // Request flags for the next poll
  localparam logic [7:0] FLG_NONE  = 8'h00;
  localparam logic [7:0] FLG_ABS   = 8'h01;
  localparam logic [7:0] FLG_LAST2 = 8'h02;
  localparam logic [7:0] FLG_ZERO  = 8'h80;

  // Bit positions of the resync requests within the flags
  localparam int unsigned FLG_ABS_BIT   = 0;
  localparam int unsigned FLG_LAST2_BIT = 1;

  // Status codes
  localparam logic [2:0] ST_NORMAL = 3'd0;
  localparam logic [2:0] ST_ABS    = 3'd1;
  localparam logic [2:0] ST_LAST2  = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_MISS   = 3'd4;

  localparam logic [1:0] MISS_SAT = 2'd2;

  // CRC-4, x^4+x+1, MSB first over word bits 31..4
  localparam logic [3:0] CRC_POLY = 4'h3;
  localparam int unsigned CRC_BITS = 28;

  typedef logic [CRC_BITS-1:0][3:0] crc_cols_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [31:0] position;
    logic [19:0] speed;
    logic [1:0]  miss;
    logic        awaiting;
  } eld_state_t;

  typedef struct packed {
    logic [7:0]  next_flags;
    logic [31:0] position;
    logic [19:0] speed;
    logic [2:0]  status;
  } eld_result_t;

  // The CRC is linear with a zero start value, so each data bit contributes a
  // fixed nibble; work out that nibble for every bit at elaboration.
  function automatic crc_cols_t crc4_cols();
    crc_cols_t   cols;
    logic [3:0]  crc;
    logic        d;
    logic        m;
    cols = '0;
    for (int j = 0; j < CRC_BITS; j++) begin
      crc = 4'h0;
      for (int i = CRC_BITS - 1; i >= 0; i--) begin
        d   = (i == j);
        m   = crc[3];
        crc = {crc[2:0], 1'b0};
        if (d ^ m) begin
          crc = crc ^ CRC_POLY;
        end
      end
      cols[j] = crc;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc4_cols();

endpackage

`default_nettype wire

@@ sv/eld_decode.sv @@
// ----------------------------------------------------------------------------
// eld_decode: frame decode and state update
// Decodes one reply word under the flags in force and yields the next state
// and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_decode
  import eld_pkg::*;
(
  input  logic        reply_ok_i,
  input  logic [31:0] reply_word_i,
  input  eld_state_t  state_i,
  output eld_state_t  state_o,
  output eld_result_t result_o
);

  logic [3:0]  crc;
  logic        resync;
  logic        crc_bad;
  logic [31:0] abs_mag;
  logic [31:0] abs_pos;
  logic [12:0] delta_hi;
  logic [12:0] delta_lo;
  logic [12:0] delta_sum;
  logic [31:0] delta_hi_ext;
  logic [31:0] delta_sum_ext;
  logic [19:0] speed_mag;
  logic [19:0] speed_val;
  logic [1:0]  miss_inc;
  eld_state_t  st;
  logic [2:0]  status;

  // XOR of the column nibbles of the set data bits
  always_comb begin
    crc = 4'h0;
    for (int j = 0; j < CRC_BITS; j++) begin
      if (reply_word_i[j+4]) begin
        crc = crc ^ CRC_COLS[j];
      end
    end
  end

  assign resync  = state_i.flags[FLG_ABS_BIT] | state_i.flags[FLG_LAST2_BIT];
  assign crc_bad = resync && (crc != reply_word_i[3:0]);

  assign abs_mag = {9'b0, reply_word_i[30:8]};
  assign abs_pos = reply_word_i[31] ? (32'd0 - abs_mag) : abs_mag;

  assign delta_hi = reply_word_i[31] ? (13'd0 - {2'b0, reply_word_i[30:20]})
                                     : {2'b0, reply_word_i[30:20]};
  assign delta_lo = reply_word_i[19] ? (13'd0 - {2'b0, reply_word_i[18:8]})
                                     : {2'b0, reply_word_i[18:8]};
  assign delta_sum     = delta_hi + delta_lo;
  assign delta_hi_ext  = {{19{delta_hi[12]}}, delta_hi};
  assign delta_sum_ext = {{19{delta_sum[12]}}, delta_sum};

  assign speed_mag = {1'b0, reply_word_i[18:0]};
  assign speed_val = reply_word_i[19] ? (20'd0 - speed_mag) : speed_mag;

  assign miss_inc = (state_i.miss == MISS_SAT) ? MISS_SAT : state_i.miss + 2'd1;

  always_comb begin
    st = state_i;
    priority if (!reply_ok_i) begin
      st.miss = miss_inc;
      status  = ST_MISS;
    end else if (crc_bad) begin
      st.miss = miss_inc;
      status  = ST_CRC;
    end else begin
      priority if (state_i.flags[FLG_ABS_BIT]) begin
        st.position = abs_pos;
        st.speed    = '0;
        status      = ST_ABS;
      end else if (state_i.flags[FLG_LAST2_BIT]) begin
        st.position = state_i.position + delta_sum_ext;
        st.speed    = '0;
        status      = ST_LAST2;
      end else begin
        st.position = state_i.position + delta_hi_ext;
        st.speed    = speed_val;
        status      = ST_NORMAL;
      end
      st.miss     = '0;
      st.awaiting = 1'b0;
    end

    priority if (st.awaiting) begin
      st.flags = FLG_ZERO;
    end else if (st.miss == 2'd1) begin
      st.flags = FLG_LAST2;
    end else if (st.miss != 2'd0) begin
      st.flags = FLG_ABS;
    end else begin
      st.flags = FLG_NONE;
    end
  end

  assign state_o           = st;
  assign result_o.next_flags = st.flags;
  assign result_o.position   = st.position;
  assign result_o.speed      = st.speed;
  assign result_o.status     = status;

endmodule

`default_nettype wire

@@ sv/encoder_link_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// encoder_link_frame_decoder: encoder reply frame decoder
// Tracks request flags, position, speed and misses across poll reports.
// ----------------------------------------------------------------------------
// Each input item reports one poll: tuser carries reply_ok, tdata the 32-bit
// reply word. The word is decoded under the request flags chosen by the
// previous item (normal frame, absolute resync or last-two resync, the
// resync frames checked by CRC-4), and one result item is produced per input
// item with the flags for the next poll, the wrapped position, the Q14 speed
// and a status code. The block takes one item per clock cycle unless the
// master side stalls it. An accepted item is loaded into the input register;
// when the result register is free or being emptied, the item moves through
// the decode logic into the result register. State is updated at that same
// edge, so the next item sees it at once. Both stages hold under
// back-pressure and fill as soon as the master side drains. After reset the
// flags request a zero frame and position, speed and miss count are zero.
`default_nettype none

module encoder_link_frame_decoder
  import eld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] reply_word
  input  logic        s_axis_tuser_i,   // [0] reply_ok
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [7:0] next_flags, [39:8] position,
                                        // [59:40] speed_q14, [63:60] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  // Input register
  logic        in_vld_q, in_vld_d;
  logic [31:0] in_word_q;
  logic        in_ok_q;

  // Result register
  logic        out_vld_q, out_vld_d;
  eld_result_t out_q;

  // Decoder state
  eld_state_t  state_q, state_d;
  eld_result_t result;

  logic advance;
  logic accept;

  // Move the held item into the result register when that register is free
  // or being emptied this cycle.
  assign advance = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  assign in_vld_d  = accept || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !m_axis_tready_i);

  eld_decode u_decode (
    .reply_ok_i   (in_ok_q),
    .reply_word_i (in_word_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (result)
  );

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q          <= 1'b0;
      out_vld_q         <= 1'b0;
      state_q.flags     <= FLG_ZERO;
      state_q.position  <= '0;
      state_q.speed     <= '0;
      state_q.miss      <= '0;
      state_q.awaiting  <= 1'b1;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= s_axis_tdata_i;
      in_ok_q   <= s_axis_tuser_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_q.speed, out_q.position, out_q.next_flags};
  assign m_axis_tuser_o  = out_q.status;

endmodule

`default_nettype wire

@@ sv/eld_checker.sv @@
// ----------------------------------------------------------------------------
// eld_checker: port-level checks for the encoder link frame decoder
// Watches the result stream and checks flag and status consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_checker
  import eld_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  // Only the four request codes go out
  a_flags_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[7:0] == FLG_NONE) || (m_axis_tdata_o[7:0] == FLG_ABS) ||
      (m_axis_tdata_o[7:0] == FLG_LAST2) || (m_axis_tdata_o[7:0] == FLG_ZERO))
    else $error("illegal request flags");

  // A miss never asks for a normal frame
  a_miss_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == ST_MISS) || (m_axis_tuser_o == ST_CRC)) |->
      m_axis_tdata_o[7:0] != FLG_NONE)
    else $error("normal request after a miss");

  // A decoded frame clears the miss count, so the next request is normal
  a_ok_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == ST_NORMAL) || (m_axis_tuser_o == ST_ABS) ||
      (m_axis_tuser_o == ST_LAST2)) |->
      m_axis_tdata_o[7:0] == FLG_NONE)
    else $error("request not normal after a decoded frame");

  // Resync frames zero the speed
  a_resync_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == ST_ABS) || (m_axis_tuser_o == ST_LAST2)) |->
      m_axis_tdata_o[59:40] == 20'd0)
    else $error("speed not cleared by resync");

endmodule

bind encoder_link_frame_decoder eld_checker u_eld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

@@ tb/sv/tb_encoder_link_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_link_frame_decoder: self-checking bench for the frame decoder
// Feeds poll reports (reply flag and reply word) through the slave stream.
// A local decoder works out the flags, position, speed and status that each
// accepted item should produce and queues them. Every result item taken from
// the master stream is checked field by field against the oldest entry.
// Directed polls walk the zero-request, last-two and absolute paths with
// extreme and negative-zero fields and CRC failures. Random polls follow,
// mostly well-formed for the flags in force, under bursty input and a
// stalling sink.
// ----------------------------------------------------------------------------

module tb_encoder_link_frame_decoder;
  import eld_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        src_valid = 1'b0;
  logic [31:0] src_word = '0;
  logic        src_ok = 1'b0;
  logic        src_ready;
  logic        sink_valid;
  logic        sink_ready = 1'b0;
  logic [63:0] sink_data;
  logic [2:0]  sink_status;

  // Decoder state as the bench tracks it
  logic [7:0]  link_flags;
  logic [31:0] track_pos;
  logic [19:0] track_speed;
  logic [1:0]  miss_run;
  logic        first_pending;

  eld_result_t pending_results[$];
  eld_result_t head_result;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned sink_mode = 0;
  int unsigned sink_mode_left = 0;
  int unsigned sink_hold_left = 0;
  int unsigned drain_wait;

  encoder_link_frame_decoder DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_word),     // [31:0] reply_word
    .s_axis_tuser_i  (src_ok),       // [0] reply_ok
    .m_axis_tvalid_o (sink_valid),
    .m_axis_tready_i (sink_ready),
    .m_axis_tdata_o  (sink_data),    // [7:0] flags, [39:8] position, [59:40] speed
    .m_axis_tuser_o  (sink_status)   // [2:0] status
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  // CRC-4, x^4+x+1, zero start, MSB first over bits 31..4
  function automatic logic [3:0] frame_crc(input logic [31:0] w);
    logic [3:0] crc;
    logic       fb;
    crc = 4'h0;
    for (int i = 31; i >= 4; i--) begin
      fb  = crc[3] ^ w[i];
      crc = {crc[2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] with_crc(input logic [31:0] w);
    return {w[31:4], frame_crc(w)};
  endfunction

  // Sign-magnitude to two's complement; a set sign on zero gives zero
  function automatic logic [31:0] signed_mag(input logic neg, input logic [22:0] mag);
    return neg ? 32'd0 - {9'd0, mag} : {9'd0, mag};
  endfunction

  // Apply one poll report to the tracked state and return the result it yields
  function automatic eld_result_t decode_poll(input logic ok, input logic [31:0] w);
    eld_result_t r;
    logic [2:0]  st;
    logic [31:0] spd;
    logic        resync;
    resync = link_flags[FLG_ABS_BIT] | link_flags[FLG_LAST2_BIT];
    if (!ok || (resync && frame_crc(w) != w[3:0])) begin
      miss_run = (miss_run == MISS_SAT) ? MISS_SAT : miss_run + 2'd1;
      st = ok ? ST_CRC : ST_MISS;
    end else begin
      if (link_flags[FLG_ABS_BIT]) begin
        track_pos   = signed_mag(w[31], w[30:8]);
        track_speed = '0;
        st = ST_ABS;
      end else if (link_flags[FLG_LAST2_BIT]) begin
        track_pos   = track_pos + signed_mag(w[19], {12'd0, w[18:8]});
        track_pos   = track_pos + signed_mag(w[31], {12'd0, w[30:20]});
        track_speed = '0;
        st = ST_LAST2;
      end else begin
        track_pos   = track_pos + signed_mag(w[31], {12'd0, w[30:20]});
        spd         = signed_mag(w[19], {4'd0, w[18:0]});
        track_speed = spd[19:0];
        st = ST_NORMAL;
      end
      miss_run      = 2'd0;
      first_pending = 1'b0;
    end
    if (first_pending) begin
      link_flags = FLG_ZERO;
    end else if (miss_run == 2'd1) begin
      link_flags = FLG_LAST2;
    end else if (miss_run > 2'd1) begin
      link_flags = FLG_ABS;
    end else begin
      link_flags = FLG_NONE;
    end
    r.next_flags = link_flags;
    r.position   = track_pos;
    r.speed      = track_speed;
    r.status     = st;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Present one poll report; open a new burst after a random gap when the
  // current one is used up, otherwise hold valid high back to back
  task automatic send_poll(input logic ok, input logic [31:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 8);
      gap = $urandom_range(1, 10);
      src_valid <= 1'b0;
      src_word  <= $urandom;
      src_ok    <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= word;
    src_ok    <= ok;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), decode_poll(ok, word));
    burst_left--;
  endtask

  // Zero request before the first success, then normal frames at the extremes
  task automatic test_startup_polls();
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h0000_0000);
    send_poll(1'b1, 32'h7FF7_FFFF);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h8008_0000);
  endtask

  // One miss asks for the last two deltas; also a CRC failure in that mode
  task automatic test_last_two_resync();
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, with_crc(32'h7FF7_FF00));
    send_poll(1'b0, 32'h1234_5678);
    send_poll(1'b1, with_crc(32'hFFFF_FFF0));
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, with_crc(32'h8008_0000));
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, with_crc(32'h0123_4560) ^ 32'h1);
  endtask

  // Saturated misses ask for the absolute position; bad and good frames
  task automatic test_absolute_resync();
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, with_crc(32'h7FFF_FF00) ^ 32'h8);
    send_poll(1'b1, with_crc(32'h7FFF_FF00));
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, with_crc(32'hFFFF_FFF0));
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, with_crc(32'h8000_0000));
    send_poll(1'b1, 32'h0000_0000);
  endtask

  // Mostly well-formed polls for the flags in force, with misses and
  // corrupted resync frames mixed in
  task automatic test_random_polls(input int unsigned count);
    logic        ok;
    logic [31:0] word;
    for (int unsigned n = 0; n < count; n++) begin
      ok   = ($urandom_range(0, 99) < 82);
      word = $urandom;
      case ($urandom_range(0, 9))
        0: word[30:20] = '1;
        1: word[30:20] = '0;
        2: word[18:0]  = '1;
        3: word[30:8]  = '1;
        4: word[18:0]  = '0;
        default: ;
      endcase
      if ((link_flags[FLG_ABS_BIT] | link_flags[FLG_LAST2_BIT]) &&
          $urandom_range(0, 99) < 85) begin
        word = with_crc(word);
      end
      send_poll(ok, word);
    end
  endtask

  // Sink readiness: switch between always ready, coin toss, mostly stalled
  // and long alternating stretches
  always @(posedge clk) begin
    if (sink_mode_left == 0) begin
      sink_mode      <= $urandom_range(0, 3);
      sink_mode_left <= $urandom_range(16, 160);
    end else begin
      sink_mode_left <= sink_mode_left - 1;
    end
    case (sink_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= ($urandom_range(0, 1) == 1);
      2: sink_ready <= ($urandom_range(0, 7) == 0);
      default: begin
        if (sink_hold_left == 0) begin
          sink_ready     <= ~sink_ready;
          sink_hold_left <= $urandom_range(1, 15);
        end else begin
          sink_hold_left <= sink_hold_left - 1;
        end
      end
    endcase
  end

  // Take each accepted result item and check it against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && sink_valid && sink_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with none expected", sink_data[39:8], 32'h0);
      end else begin
        head_result = pending_results.pop_front();
        if (sink_data[7:0] !== head_result.next_flags)
          note_mismatch("next_flags", 32'(sink_data[7:0]), 32'(head_result.next_flags));
        if (sink_data[39:8] !== head_result.position)
          note_mismatch("position", sink_data[39:8], head_result.position);
        if (sink_data[59:40] !== head_result.speed)
          note_mismatch("speed_q14", 32'(sink_data[59:40]), 32'(head_result.speed));
        if (sink_data[63:60] !== 4'h0)
          note_mismatch("tdata padding", 32'(sink_data[63:60]), 32'h0);
        if (sink_status !== head_result.status)
          note_mismatch("status", 32'(sink_status), 32'(head_result.status));
      end
    end
  end

  initial begin
    link_flags    = FLG_ZERO;
    track_pos     = '0;
    track_speed   = '0;
    miss_run      = 2'd0;
    first_pending = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_startup_polls();
    test_last_two_resync();
    test_absolute_resync();
    test_random_polls(1950);
    src_valid <= 1'b0;

    // Drain, then allow for the two-stage pipeline plus margin
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch("results never delivered", 32'(pending_results.size()), 32'h0);
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
